FILE: sv/fpwsm_pkg.sv
`timescale 1ns / 1ps

package fpwsm_pkg;

  // geometry of the monitored image
  localparam int unsigned PAGE_BYTES = 256;
  localparam int unsigned MAX_PAGES  = 1024;
  localparam int unsigned PAGE_BITS  = $clog2(PAGE_BYTES);
  localparam int unsigned PAGE_IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

  // field widths
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned SPAN_W    = 19;
  localparam int unsigned RSPAN_W   = SPAN_W + 1;
  localparam int unsigned CMP_W     = ADDR_W + 1;
  localparam int unsigned CNT32_W   = 32;
  localparam int unsigned CNT11_W   = 11;
  localparam int unsigned ERASE_W   = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CMP_W-1:0] SPAN_LIM = CMP_W'(MAX_PAGES * PAGE_BYTES);
  localparam logic [ERASE_W-1:0] ERASE_SAT = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SPAN = 1'd1;

  // access kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RD_OOB   = 2'd1,
    ST_WR_OOB   = 2'd2,
    ST_WR_UNAL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    GATE_CLEAN     = 3'd0,
    GATE_UNALIGNED = 3'd1,
    GATE_OOB_WRITE = 3'd2,
    GATE_OOB_READ  = 3'd3,
    GATE_AMPLIFIED = 3'd4,
    GATE_INVERSION = 3'd5
  } gate_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
  } fpwsm_in_t;

  typedef struct packed {
    logic [1:0]         access_status;
    logic [2:0]         gate_code;
    logic [CNT32_W-1:0] erase_total;
    logic [CNT11_W-1:0] pages_erased;
    logic [CNT11_W-1:0] amplified_pages;
    logic [CNT32_W-1:0] inversion_count;
  } fpwsm_out_t;

  // write-back into the erase-count store
  typedef struct packed {
    logic                  en;
    logic [PAGE_IDX_W-1:0] page;
    logic [ERASE_W-1:0]    count;
  } fpwsm_wr_t;

  function automatic logic [CNT32_W-1:0] sat_inc32(input logic [CNT32_W-1:0] v);
    return (v == '1) ? v : v + CNT32_W'(1);
  endfunction

  function automatic logic [CNT11_W-1:0] sat_inc11(input logic [CNT11_W-1:0] v);
    return (v == '1) ? v : v + CNT11_W'(1);
  endfunction

endpackage

FILE: sv/fpwsm_page_store.sv
`timescale 1ns / 1ps

module fpwsm_page_store
  import fpwsm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [PAGE_IDX_W-1:0] rd_page_i,
  input  fpwsm_wr_t             wr_i,
  output logic [ERASE_W-1:0]    rd_count_o,
  output logic                  clr_busy_o
);

  logic [ERASE_W-1:0]    mem_q [MAX_PAGES];
  logic [ERASE_W-1:0]    rd_q;
  logic [PAGE_IDX_W-1:0] clr_idx_q, clr_idx_d;
  logic                  clr_busy_q, clr_busy_d;

  // clearing pass after reset, one entry a cycle
  always_comb begin
    clr_idx_d  = clr_idx_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_idx_d = clr_idx_q + PAGE_IDX_W'(1);
      if (clr_idx_q == PAGE_IDX_W'(MAX_PAGES - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_idx_q  <= clr_idx_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // single write port, shared by the clearing pass and the write-back
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_idx_q] <= '0;
    end else if (wr_i.en) begin
      mem_q[wr_i.page] <= wr_i.count;
    end
  end

  // registered read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_page_i];
    end
  end

  assign rd_count_o = rd_q;
  assign clr_busy_o = clr_busy_q;

  // nothing else may touch the store while it is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !wr_i.en && !rd_en_i)
    else $error("store accessed during clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_busy_q) |-> $past(clr_idx_q) == PAGE_IDX_W'(MAX_PAGES - 1))
    else $error("clearing pass ended early");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_busy_q |=> !clr_busy_q)
    else $error("clearing pass restarted");

endmodule

FILE: sv/flash_page_write_safety_monitor.sv
`timescale 1ns / 1ps

// Flash page-write safety monitor. Each transaction on the input channel is a
// byte read or a page erase-and-program at an absolute address; each gives one
// result transaction with the access status, the gate code of the highest-
// priority failure kind seen so far and the saturating counters as they stand
// after that access. A transaction passes from acceptance through the address
// offset, the bounds check with erase-count read and the read-modify-write of
// the count into the output register, with the per-page erase-count memory
// read registered between the last two steps; one transaction is in flight at
// a time, and the next one is accepted only once the previous result has
// entered the output register, which an output stall can delay. After reset
// all MAX_PAGES (1024) erase-count entries are cleared while input is stalled;
// configuration writes are taken at any time but belong in idle periods.
module flash_page_write_safety_monitor
  import fpwsm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  fpwsm_in_t             in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output fpwsm_out_t            out_data_o
);

  // configuration
  logic [ADDR_W-1:0] image_base_q;
  logic [SPAN_W-1:0] image_span_q;

  // stage valids
  logic acc_q, chk_q, upd_q;
  logic in_fire, upd_fire;

  // first stage payload
  fpwsm_in_t         acc_item_q;
  logic              chk_kind_q, chk_below_q;
  logic [ADDR_W-1:0] chk_rel_q;

  // second stage results
  logic [RSPAN_W-1:0]    span_sum;
  logic [CMP_W-1:0]      span_round, span_eff;
  logic [CMP_W-1:0]      rel_ext;
  status_e               chk_status;
  logic                  chk_wr_ok;
  logic [PAGE_IDX_W-1:0] chk_page;
  status_e               upd_status_q;
  logic                  upd_wr_ok_q;
  logic [PAGE_IDX_W-1:0] upd_page_q;

  // store interface
  logic               clr_busy;
  logic [ERASE_W-1:0] rd_count;
  fpwsm_wr_t          wr;

  // persistent monitor state
  logic [PAGE_IDX_W-1:0] last_page_q, last_page_d;
  dir_e                  front_q, front_d, step_dir;
  logic                  seen_q, seen_d;
  logic [CNT32_W-1:0]    erase_cnt_q, erase_cnt_d;
  logic [CNT11_W-1:0]    erased_q, erased_d;
  logic [CNT11_W-1:0]    amp_q, amp_d;
  logic [CNT32_W-1:0]    inv_q, inv_d;
  logic [CNT32_W-1:0]    unal_q, unal_d;
  logic [CNT32_W-1:0]    oobw_q, oobw_d;
  logic [CNT32_W-1:0]    oobr_q, oobr_d;
  gate_e                 gate_d;

  // output register
  logic       out_valid_q;
  fpwsm_out_t out_q;

  assign in_stall_o = clr_busy || acc_q || chk_q || upd_q;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign upd_fire   = upd_q && !(out_valid_q && out_stall_i);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_base_q <= '0;
      image_span_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_BASE: image_base_q <= cfg_wdata_i;
        CFG_IMAGE_SPAN: image_span_q <= cfg_wdata_i[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 1'b0;
      chk_q <= 1'b0;
      upd_q <= 1'b0;
    end else begin
      acc_q <= in_fire;
      chk_q <= acc_q;
      if (chk_q) begin
        upd_q <= 1'b1;
      end else if (upd_fire) begin
        upd_q <= 1'b0;
      end
    end
  end

  // capture the transaction
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      acc_item_q <= in_data_i;
    end
  end

  // offset from the image base
  always_ff @(posedge clk_i) begin
    if (acc_q) begin
      chk_kind_q  <= acc_item_q.kind;
      chk_below_q <= acc_item_q.address < image_base_q;
      chk_rel_q   <= acc_item_q.address - image_base_q;
    end
  end

  // span rounded up to whole pages and clamped
  always_comb begin
    span_sum   = RSPAN_W'(image_span_q) + RSPAN_W'(PAGE_BYTES - 1);
    span_round = CMP_W'({span_sum[RSPAN_W-1:PAGE_BITS], PAGE_BITS'(0)});
    span_eff   = (span_round > SPAN_LIM) ? SPAN_LIM : span_round;
    rel_ext    = CMP_W'(chk_rel_q);
    chk_page   = chk_rel_q[PAGE_BITS +: PAGE_IDX_W];
  end

  // bounds and alignment checks
  always_comb begin
    chk_status = ST_OK;
    chk_wr_ok  = 1'b0;
    if (chk_kind_q == KIND_READ) begin
      if (chk_below_q || (rel_ext >= span_eff)) begin
        chk_status = ST_RD_OOB;
      end
    end else begin
      if (chk_below_q) begin
        chk_status = ST_WR_OOB;
      end else if (chk_rel_q[PAGE_BITS-1:0] != '0) begin
        chk_status = ST_WR_UNAL;
      end else if (rel_ext + CMP_W'(PAGE_BYTES) > span_eff) begin
        chk_status = ST_WR_OOB;
      end else begin
        chk_wr_ok = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (chk_q) begin
      upd_status_q <= chk_status;
      upd_wr_ok_q  <= chk_wr_ok;
      upd_page_q   <= chk_page;
    end
  end

  // erase-count memory; one transaction in flight, so a read never meets a
  // pending write-back to the same page
  fpwsm_page_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (chk_q && chk_wr_ok),
    .rd_page_i  (chk_page),
    .wr_i       (wr),
    .rd_count_o (rd_count),
    .clr_busy_o (clr_busy)
  );

  // direction of this page write against the last one
  always_comb begin
    if (upd_page_q > last_page_q) begin
      step_dir = DIR_UP;
    end else if (upd_page_q < last_page_q) begin
      step_dir = DIR_DOWN;
    end else begin
      step_dir = DIR_NONE;
    end
  end

  // read-modify-write of the erase count and counter updates
  always_comb begin
    last_page_d = last_page_q;
    front_d     = front_q;
    seen_d      = seen_q;
    erase_cnt_d = erase_cnt_q;
    erased_d    = erased_q;
    amp_d       = amp_q;
    inv_d       = inv_q;
    unal_d      = unal_q;
    oobw_d      = oobw_q;
    oobr_d      = oobr_q;
    wr.en       = 1'b0;
    wr.page     = upd_page_q;
    wr.count    = rd_count + ERASE_W'(1);
    case (upd_status_q)
      ST_RD_OOB:  oobr_d = sat_inc32(oobr_q);
      ST_WR_OOB:  oobw_d = sat_inc32(oobw_q);
      ST_WR_UNAL: unal_d = sat_inc32(unal_q);
      default: ;
    endcase
    if (upd_wr_ok_q) begin
      erase_cnt_d = sat_inc32(erase_cnt_q);
      if (rd_count != ERASE_SAT) begin
        wr.en = upd_fire;
        if (rd_count == ERASE_W'(0)) begin
          erased_d = sat_inc11(erased_q);
        end else if (rd_count == ERASE_W'(1)) begin
          amp_d = sat_inc11(amp_q);
        end
      end
      if (seen_q && step_dir != DIR_NONE) begin
        if (front_q == DIR_NONE) begin
          front_d = step_dir;
        end else if (step_dir != front_q) begin
          inv_d = sat_inc32(inv_q);
        end
      end
      last_page_d = upd_page_q;
      seen_d      = 1'b1;
    end
  end

  // highest-priority failure kind seen so far
  always_comb begin
    if (unal_d != '0) begin
      gate_d = GATE_UNALIGNED;
    end else if (oobw_d != '0) begin
      gate_d = GATE_OOB_WRITE;
    end else if (oobr_d != '0) begin
      gate_d = GATE_OOB_READ;
    end else if (amp_d != '0) begin
      gate_d = GATE_AMPLIFIED;
    end else if (inv_d != '0) begin
      gate_d = GATE_INVERSION;
    end else begin
      gate_d = GATE_CLEAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_page_q <= '0;
      front_q     <= DIR_NONE;
      seen_q      <= 1'b0;
      erase_cnt_q <= '0;
      erased_q    <= '0;
      amp_q       <= '0;
      inv_q       <= '0;
      unal_q      <= '0;
      oobw_q      <= '0;
      oobr_q      <= '0;
    end else if (upd_fire) begin
      last_page_q <= last_page_d;
      front_q     <= front_d;
      seen_q      <= seen_d;
      erase_cnt_q <= erase_cnt_d;
      erased_q    <= erased_d;
      amp_q       <= amp_d;
      inv_q       <= inv_d;
      unal_q      <= unal_d;
      oobw_q      <= oobw_d;
      oobr_q      <= oobr_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      out_q.access_status   <= upd_status_q;
      out_q.gate_code       <= gate_d;
      out_q.erase_total     <= erase_cnt_d;
      out_q.pages_erased    <= erased_d;
      out_q.amplified_pages <= amp_d;
      out_q.inversion_count <= inv_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // only one transaction in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({acc_q, chk_q, upd_q}))
    else $error("more than one transaction in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !(acc_q || chk_q || upd_q))
    else $error("transaction in flight during clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    amp_q <= erased_q)
    else $error("more amplified pages than erased pages");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inv_q != '0) |-> (front_q != DIR_NONE))
    else $error("inversion counted without a frontier direction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 erase_cnt_q >= $past(erase_cnt_q))
    else $error("erase total decreased");

endmodule
